@@ src/gcode_extrusion_path_extractor_macros.svh @@
// Assertion macros used by the checker file of the extrusion path extractor.
`ifndef GCODE_EXTRUSION_PATH_EXTRACTOR_MACROS_SVH
`define GCODE_EXTRUSION_PATH_EXTRACTOR_MACROS_SVH

// Antecedent at one edge implies the consequent at the next edge, outside reset.
`define GCPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// A reset edge must leave the consequent true at the next edge.
`define GCPE_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

@@ src/gcpe_pkg.sv @@
// ----------------------------------------------------------------------------
// gcpe_pkg
// Types and codes of the G-code extrusion path extractor.
// ----------------------------------------------------------------------------
package gcpe_pkg;

  // G and M numbers that the interpreter acts on.
  localparam logic [7:0] G_RAPID   = 8'd0;
  localparam logic [7:0] G_LINEAR  = 8'd1;
  localparam logic [7:0] G_ABS_POS = 8'd90;
  localparam logic [7:0] G_REL_POS = 8'd91;
  localparam logic [7:0] G_SET_POS = 8'd92;
  localparam logic [7:0] M_ABS_EXT = 8'd82;
  localparam logic [7:0] M_REL_EXT = 8'd83;

  // Motion mode codes.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_G0   = 2'd1;
  localparam logic [1:0] MODE_G1   = 2'd2;

  localparam logic signed [47:0] COORD_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] COORD_MIN = 48'sh8000_0000_0000;
  localparam logic [31:0]        SEG_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic              has_g;
    logic [7:0]        g_number;
    logic              has_m;
    logic [7:0]        m_number;
    logic              has_x;
    logic signed [47:0] x_word;
    logic              has_y;
    logic signed [47:0] y_word;
    logic              has_z;
    logic signed [47:0] z_word;
    logic              has_e;
    logic signed [47:0] e_word;
  } line_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic signed [47:0] ext_pos;
    logic               abs_moves;
    logic               abs_ext;
    logic [1:0]         mode;
    logic [31:0]        next_seg;
    logic               seg_open;
  } state_t;

  typedef struct packed {
    logic signed [47:0] point_x;
    logic signed [47:0] point_y;
    logic signed [47:0] point_z;
    logic [31:0]        segment_number;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [1:0] count;
    point_t     pt0;
    point_t     pt1;
  } step_res_t;

endpackage

@@ src/gcpe_if.sv @@
// ----------------------------------------------------------------------------
// gcpe_if
// Valid/ready channels of the extrusion path extractor: parsed lines, path
// points and the configuration write.
// ----------------------------------------------------------------------------
interface gcpe_line_if;
  logic               valid;
  logic               ready;
  logic               has_g;
  logic [7:0]         g_number;
  logic               has_m;
  logic [7:0]         m_number;
  logic               has_x;
  logic signed [47:0] x_word;
  logic               has_y;
  logic signed [47:0] y_word;
  logic               has_z;
  logic signed [47:0] z_word;
  logic               has_e;
  logic signed [47:0] e_word;

  modport source (
    output valid, has_g, g_number, has_m, m_number, has_x, x_word,
           has_y, y_word, has_z, z_word, has_e, e_word,
    input  ready
  );
  modport sink (
    input  valid, has_g, g_number, has_m, m_number, has_x, x_word,
           has_y, y_word, has_z, z_word, has_e, e_word,
    output ready
  );
endinterface

interface gcpe_point_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] point_x;
  logic signed [47:0] point_y;
  logic signed [47:0] point_z;
  logic [31:0]        segment_number;
  logic               last_point;

  modport source (
    output valid, point_x, point_y, point_z, segment_number, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, segment_number, last_point,
    output ready
  );
endinterface

interface gcpe_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] min_extrusion_step;

  modport source (output valid, min_extrusion_step, input ready);
  modport sink   (input valid, min_extrusion_step, output ready);
endinterface

@@ src/gcode_extrusion_path_extractor.sv @@
// ----------------------------------------------------------------------------
// gcode_extrusion_path_extractor
// Modal G-code interpreter that turns parsed lines into extrusion path points.
// ----------------------------------------------------------------------------
//   Channel  Dir  Beat
//   in_ch    in   one parsed G-code line
//   out_ch   out  one path point with its segment number
//   cfg_ch   in   new min_extrusion_step value
//
// A line is held in the input register and is resolved into up to two
// points in one pass, which are loaded into the two-entry output buffer.
// The output channel moves one point per cycle while out_ready is high; a line
// that opens a segment loads two points, any other printing line one, others none.
// A line's first point passes the input register and then the output buffer.
// rst_n is synchronous and restores the power-up modal state and threshold.
// With out_ready low the head point holds and one further line can be taken.
module gcode_extrusion_path_extractor (
  input  logic         clk,
  input  logic         rst_n,
  gcpe_line_if.sink    in_ch,
  gcpe_point_if.source out_ch,
  gcpe_cfg_if.sink     cfg_ch
);
  import gcpe_pkg::*;

  logic [15:0] min_step_r;
  line_t       line_r, line_nxt;
  logic        line_v_r;
  state_t      st_r, st_nxt;
  step_res_t   res_nxt;
  point_t      slot_a_r, slot_b_r;
  logic [1:0]  cnt_r;
  logic        in_acc, pop, advance;

  assign pop     = (cnt_r != 2'd0) && out_ch.ready;
  assign advance = line_v_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop));
  assign in_ch.ready = !line_v_r || advance;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    line_nxt.has_g    = in_ch.has_g;
    line_nxt.g_number = in_ch.g_number;
    line_nxt.has_m    = in_ch.has_m;
    line_nxt.m_number = in_ch.m_number;
    line_nxt.has_x    = in_ch.has_x;
    line_nxt.x_word   = in_ch.x_word;
    line_nxt.has_y    = in_ch.has_y;
    line_nxt.y_word   = in_ch.y_word;
    line_nxt.has_z    = in_ch.has_z;
    line_nxt.z_word   = in_ch.z_word;
    line_nxt.has_e    = in_ch.has_e;
    line_nxt.e_word   = in_ch.e_word;
  end

  gcpe_step u_step (
    .line_i     (line_r),
    .st_i       (st_r),
    .min_step_i (min_step_r),
    .st_o       (st_nxt),
    .res_o      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_step_r     <= 16'd0;
      line_v_r       <= 1'b0;
      cnt_r          <= 2'd0;
      st_r.pos_x     <= '0;
      st_r.pos_y     <= '0;
      st_r.pos_z     <= '0;
      st_r.ext_pos   <= '0;
      st_r.abs_moves <= 1'b1;
      st_r.abs_ext   <= 1'b1;
      st_r.mode      <= MODE_NONE;
      st_r.next_seg  <= 32'd0;
      st_r.seg_open  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        min_step_r <= cfg_ch.min_extrusion_step;
      end
      if (in_acc) begin
        line_v_r <= 1'b1;
      end else if (advance) begin
        line_v_r <= 1'b0;
      end
      if (advance) begin
        st_r  <= st_nxt;
        cnt_r <= res_nxt.count;
      end else if (pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_r <= line_nxt;
    end
    if (advance) begin
      slot_a_r <= res_nxt.pt0;
      slot_b_r <= res_nxt.pt1;
    end else if (pop) begin
      slot_a_r <= slot_b_r;
    end
  end

  assign out_ch.valid          = (cnt_r != 2'd0);
  assign out_ch.point_x        = slot_a_r.point_x;
  assign out_ch.point_y        = slot_a_r.point_y;
  assign out_ch.point_z        = slot_a_r.point_z;
  assign out_ch.segment_number = slot_a_r.segment_number;
  assign out_ch.last_point     = slot_a_r.last_point;

endmodule

@@ src/gcpe_step.sv @@
// ----------------------------------------------------------------------------
// gcpe_step
// Next modal state and emitted path points for one parsed G-code line.
// ----------------------------------------------------------------------------
module gcpe_step (
  input  gcpe_pkg::line_t     line_i,
  input  gcpe_pkg::state_t    st_i,
  input  logic [15:0]         min_step_i,
  output gcpe_pkg::state_t    st_o,
  output gcpe_pkg::step_res_t res_o
);
  import gcpe_pkg::*;

  function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      sat_add48 = s[48] ? COORD_MIN : COORD_MAX;
    end else begin
      sat_add48 = s[47:0];
    end
  endfunction

  logic               is_g90, is_g91, is_g92, g_early, m_early;
  logic               has_pos, move_ok, printing, opening;
  logic [1:0]         mode_sel;
  logic signed [47:0] tx, ty, tz, te;
  logic signed [48:0] delta, step_ext;
  logic [31:0]        seg_inc, seg_num;
  point_t             start_pt, target_pt;

  assign is_g90  = line_i.has_g && (line_i.g_number == G_ABS_POS);
  assign is_g91  = line_i.has_g && (line_i.g_number == G_REL_POS);
  assign is_g92  = line_i.has_g && (line_i.g_number == G_SET_POS);
  assign g_early = is_g90 || is_g91 || is_g92;
  assign m_early = !g_early && line_i.has_m &&
                   ((line_i.m_number == M_ABS_EXT) || (line_i.m_number == M_REL_EXT));

  always_comb begin
    mode_sel = st_i.mode;
    if (line_i.has_g && (line_i.g_number == G_RAPID)) begin
      mode_sel = MODE_G0;
    end else if (line_i.has_g && (line_i.g_number == G_LINEAR)) begin
      mode_sel = MODE_G1;
    end
  end

  assign has_pos = line_i.has_x || line_i.has_y || line_i.has_z;
  assign move_ok = !g_early && !m_early &&
                   ((mode_sel == MODE_G0) || (mode_sel == MODE_G1)) &&
                   (has_pos || line_i.has_e);

  assign tx = !line_i.has_x ? st_i.pos_x :
              st_i.abs_moves ? line_i.x_word : sat_add48(st_i.pos_x, line_i.x_word);
  assign ty = !line_i.has_y ? st_i.pos_y :
              st_i.abs_moves ? line_i.y_word : sat_add48(st_i.pos_y, line_i.y_word);
  assign tz = !line_i.has_z ? st_i.pos_z :
              st_i.abs_moves ? line_i.z_word : sat_add48(st_i.pos_z, line_i.z_word);
  assign te = !line_i.has_e ? st_i.ext_pos :
              st_i.abs_ext ? line_i.e_word : sat_add48(st_i.ext_pos, line_i.e_word);

  // The absolute-mode increase is kept at 49 bits so it cannot wrap.
  always_comb begin
    if (!line_i.has_e) begin
      delta = 49'sd0;
    end else if (st_i.abs_ext) begin
      delta = {line_i.e_word[47], line_i.e_word} - {st_i.ext_pos[47], st_i.ext_pos};
    end else begin
      delta = {line_i.e_word[47], line_i.e_word};
    end
  end

  assign step_ext = $signed({33'd0, min_step_i});
  assign printing = (mode_sel == MODE_G1) && has_pos && (delta > step_ext);
  assign opening  = printing && !st_i.seg_open;
  assign seg_inc  = (opening && (st_i.next_seg != SEG_MAX)) ? st_i.next_seg + 32'd1
                                                            : st_i.next_seg;
  assign seg_num  = seg_inc - 32'd1;

  always_comb begin
    start_pt.point_x        = st_i.pos_x;
    start_pt.point_y        = st_i.pos_y;
    start_pt.point_z        = st_i.pos_z;
    start_pt.segment_number = seg_num;
    start_pt.last_point     = 1'b0;
    target_pt.point_x        = tx;
    target_pt.point_y        = ty;
    target_pt.point_z        = tz;
    target_pt.segment_number = seg_num;
    target_pt.last_point     = 1'b1;
  end

  always_comb begin
    st_o      = st_i;
    st_o.mode = g_early ? st_i.mode : mode_sel;
    if (is_g90) begin
      st_o.abs_moves = 1'b1;
    end
    if (is_g91) begin
      st_o.abs_moves = 1'b0;
    end
    if (is_g92) begin
      if (line_i.has_x) st_o.pos_x = line_i.x_word;
      if (line_i.has_y) st_o.pos_y = line_i.y_word;
      if (line_i.has_z) st_o.pos_z = line_i.z_word;
      if (line_i.has_e) st_o.ext_pos = line_i.e_word;
      st_o.seg_open = 1'b0;
    end
    if (m_early) begin
      st_o.abs_ext = (line_i.m_number == M_ABS_EXT);
    end
    if (move_ok) begin
      st_o.pos_x    = tx;
      st_o.pos_y    = ty;
      st_o.pos_z    = tz;
      st_o.ext_pos  = te;
      st_o.next_seg = seg_inc;
      if (printing) begin
        st_o.seg_open = 1'b1;
      end else if ((mode_sel == MODE_G0) || has_pos || (delta <= 49'sd0)) begin
        // A G1 line that only pushes filament keeps the segment open.
        st_o.seg_open = 1'b0;
      end
    end
  end

  always_comb begin
    if (!move_ok || !printing) begin
      res_o.count = 2'd0;
    end else if (opening) begin
      res_o.count = 2'd2;
    end else begin
      res_o.count = 2'd1;
    end
    res_o.pt0 = opening ? start_pt : target_pt;
    res_o.pt1 = target_pt;
  end

endmodule

@@ src/gcpe_checker.sv @@
// ----------------------------------------------------------------------------
// gcpe_checker
// Port-level checks on the path point channel of the extractor.
// ----------------------------------------------------------------------------
`include "gcode_extrusion_path_extractor_macros.svh"

module gcpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] point_x,
  input logic signed [47:0] point_y,
  input logic signed [47:0] point_z,
  input logic [31:0]        segment_number,
  input logic               last_point
);

  // A stalled point beat keeps its payload.
  `GCPE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(point_x) && $stable(point_y) && $stable(point_z) && $stable(segment_number) && $stable(last_point), "stalled point beat changed")

  `GCPE_ASSERT_AFTER_RESET(a_reset_idle, clk, rst_n, !out_valid, "point beat offered right after reset")

  // A segment start point is always followed at once by its target point.
  `GCPE_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && out_ready && !last_point, out_valid && last_point, "segment start not followed by its target")

  `GCPE_ASSERT_NEXT(a_pair_segment, clk, rst_n, out_valid && out_ready && !last_point, segment_number == $past(segment_number), "segment number changed inside a point pair")

endmodule

bind gcode_extrusion_path_extractor gcpe_checker u_gcpe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .point_x        (out_ch.point_x),
  .point_y        (out_ch.point_y),
  .point_z        (out_ch.point_z),
  .segment_number (out_ch.segment_number),
  .last_point     (out_ch.last_point)
);
